[src/bdq_pkg.sv]
// Shared types and constants for the bounded deque core.
package bdq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int OP_W         = 3;
  localparam int STAT_W       = 2;
  localparam int CNT_OUT_W    = 5;

  // Operation codes of a request
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_DELETE     = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } stat_t;

  // Controller states
  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic exec;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

[src/bounded_deque_with_value_delete_core.sv]
// Top level of the bounded deque core with delete by value.
// A request is captured in the request register, and its chain update then writes the result register.
// A new request is not accepted until the current one has made its chain update.
// Backpressure on the result holds the chain update until the result register frees up.
// Reset (rst_n low, synchronous) empties the store and drops any pending result;
// cell contents are not cleared and only cells below the count ever reach a result.
module bounded_deque_with_value_delete_core #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [2:0] operation, [34:3] value, [39:35] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [33:2] removed_value,
                                  // [38:34] entry_count, [39] zero
);

  bdq_pkg::cmd_t                    cmd;
  bdq_pkg::dp_stat_t                dp_stat;
  logic [bdq_pkg::STAT_W-1:0]       status;
  logic signed [bdq_pkg::VAL_W-1:0] removed_value;
  logic [bdq_pkg::CNT_OUT_W-1:0]    entry_count;

  bdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .dp_stat    (dp_stat),
    .cmd        (cmd)
  );

  bdq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .dp_stat           (dp_stat),
    .in_operation      (in_tdata[2:0]),
    .in_value          (in_tdata[34:3]),
    .out_tready        (out_tready),
    .out_tvalid        (out_tvalid),
    .out_status        (status),
    .out_removed_value (removed_value),
    .out_entry_count   (entry_count)
  );

  // Pack the result
  assign out_tdata = {1'b0, entry_count, removed_value, status};

endmodule

[src/bdq_ctrl.sv]
// Controller state machine: accepts a request, then runs it through the cell chain.
module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  input  bdq_pkg::dp_stat_t dp_stat,
  output bdq_pkg::cmd_t     cmd
);

  bdq_pkg::state_t state_r;
  bdq_pkg::state_t state_nxt;
  logic            slot_free;

  // Result slot can take a new result this cycle
  assign slot_free = !dp_stat.out_full || out_tready;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = bdq_pkg::S_EXEC;
      end
      bdq_pkg::S_EXEC: begin
        if (slot_free) state_nxt = bdq_pkg::S_IDLE;
      end
      default: state_nxt = bdq_pkg::S_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    in_tready    = 1'b0;
    cmd.load_req = 1'b0;
    cmd.exec     = 1'b0;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      bdq_pkg::S_EXEC: begin
        cmd.exec = slot_free;
      end
      default: ;
    endcase
  end

endmodule

[src/bdq_datapath.sv]
// Datapath: request register, deque cell chain, entry count and result register.
module bdq_datapath #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdq_pkg::cmd_t                     cmd,
  output bdq_pkg::dp_stat_t                 dp_stat,
  input  logic [bdq_pkg::OP_W-1:0]          in_operation,
  input  logic signed [bdq_pkg::VAL_W-1:0]  in_value,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [bdq_pkg::STAT_W-1:0]        out_status,
  output logic signed [bdq_pkg::VAL_W-1:0]  out_removed_value,
  output logic [bdq_pkg::CNT_OUT_W-1:0]     out_entry_count
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDXW  = $clog2(CAPACITY);
  localparam int EXTW  = CW + bdq_pkg::CNT_OUT_W;

  // Request register
  logic [bdq_pkg::OP_W-1:0]         op_r;
  logic signed [bdq_pkg::VAL_W-1:0] val_r;

  // Cell chain, cell 0 is the front
  logic signed [bdq_pkg::VAL_W-1:0] cell_r   [CAPACITY];
  logic signed [bdq_pkg::VAL_W-1:0] cell_nxt [CAPACITY];
  logic [CW-1:0]                    count_r;
  logic [CW-1:0]                    count_nxt;

  // Result register
  logic                             out_valid_r;
  logic [bdq_pkg::STAT_W-1:0]       status_r;
  logic signed [bdq_pkg::VAL_W-1:0] removed_r;
  logic [bdq_pkg::CNT_OUT_W-1:0]    cnt_out_r;

  logic [bdq_pkg::STAT_W-1:0]       status_nxt;
  logic signed [bdq_pkg::VAL_W-1:0] removed_nxt;
  logic [EXTW-1:0]                  cnt_ext;

  logic [CAPACITY-1:0]              match;
  logic [CAPACITY-1:0]              hit;
  logic                             is_full;
  logic                             is_empty;
  logic [IDXW-1:0]                  back_idx;

  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign back_idx = IDXW'(count_r - CW'(1));

  // Compare each held cell against the request value; mark cells at or past the first hit
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < count_r) && (cell_r[i] == val_r);
    end
    hit[0] = match[0];
    for (int i = 1; i < CAPACITY; i++) begin
      hit[i] = hit[i-1] | match[i];
    end
  end

  // Work out next cells, count and result
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    count_nxt   = count_r;
    status_nxt  = bdq_pkg::STAT_OK;
    removed_nxt = '0;
    unique case (op_r)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = bdq_pkg::STAT_FULL;
        end else begin
          cell_nxt[0] = val_r;
          for (int i = 1; i < CAPACITY; i++) begin
            cell_nxt[i] = cell_r[i-1];
          end
          count_nxt = count_r + CW'(1);
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = bdq_pkg::STAT_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == count_r) cell_nxt[i] = val_r;
          end
          count_nxt = count_r + CW'(1);
        end
      end
      bdq_pkg::OP_DELETE: begin
        if (is_empty) begin
          status_nxt = bdq_pkg::STAT_EMPTY;
        end else if (!hit[CAPACITY-1]) begin
          status_nxt = bdq_pkg::STAT_NOT_FOUND;
        end else begin
          // Close the gap behind the first match
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (hit[i]) cell_nxt[i] = cell_r[i+1];
          end
          removed_nxt = val_r;
          count_nxt   = count_r - CW'(1);
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = bdq_pkg::STAT_EMPTY;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            cell_nxt[i] = cell_r[i+1];
          end
          removed_nxt = cell_r[0];
          count_nxt   = count_r - CW'(1);
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (is_empty) begin
          status_nxt = bdq_pkg::STAT_EMPTY;
        end else begin
          removed_nxt = cell_r[back_idx];
          count_nxt   = count_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Mask the count to the result field
  assign cnt_ext = EXTW'(count_nxt);

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= in_operation;
      val_r <= in_value;
    end
  end

  // Update the cell chain
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
    end
  end

  // Hold count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      cnt_out_r <= cnt_ext[bdq_pkg::CNT_OUT_W-1:0];
    end
  end

  assign dp_stat.out_full  = out_valid_r;
  assign out_tvalid        = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_entry_count   = cnt_out_r;

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A refused push leaves the count alone
  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && status_nxt == bdq_pkg::STAT_FULL) |=> count_r == $past(count_r))
    else $error("refused push changed count");

  // A result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || out_tready))
    else $error("result overwritten");

  // Full status only reported on a full store
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && status_nxt == bdq_pkg::STAT_FULL) |-> is_full)
    else $error("full status on non-full store");

endmodule

[verif/bounded_deque_with_value_delete_core_tb.sv]
// Self-checking testbench for the bounded deque core: directed and random requests.
`timescale 1ns / 1ps

module bounded_deque_with_value_delete_core_tb;

  localparam int DEPTH          = bdq_pkg::CAPACITY_DEF;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 100;

  // Operation codes outside the defined set; the core must treat them as no-ops
  localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic [bdq_pkg::VAL_W-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [bdq_pkg::VAL_W-1:0] VAL_MAX    = 32'h7FFF_FFFF;
  localparam logic [bdq_pkg::VAL_W-1:0] VAL_ONES   = 32'hFFFF_FFFF;
  localparam logic [bdq_pkg::VAL_W-1:0] VAL_ABSENT = 32'h1234_5678;

  typedef struct packed {
    bdq_pkg::stat_t                status;
    logic [bdq_pkg::VAL_W-1:0]     removed_value;
    logic [bdq_pkg::CNT_OUT_W-1:0] entry_count;
  } deque_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [2:0] operation, [34:3] value, [39:35] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [1:0] status, [33:2] removed_value, [38:34] entry_count

  // Shadow copy of the deque contents, front at index 0
  logic [bdq_pkg::VAL_W-1:0] held_values[$];
  deque_result_t             pending_results[$];

  int  mismatch_count;
  int  burst_left;
  bit  hold_off_req;

  bounded_deque_with_value_delete_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow deque and return the result it should give
  function automatic deque_result_t apply_deque_op(input logic [bdq_pkg::OP_W-1:0] op,
                                                   input logic [bdq_pkg::VAL_W-1:0] val);
    deque_result_t res;
    int            hit;
    res.status        = bdq_pkg::STAT_OK;
    res.removed_value = '0;
    hit               = -1;
    case (op)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (held_values.size() >= DEPTH) res.status = bdq_pkg::STAT_FULL;
        else held_values.push_front(val);
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (held_values.size() >= DEPTH) res.status = bdq_pkg::STAT_FULL;
        else held_values.push_back(val);
      end
      bdq_pkg::OP_DELETE: begin
        if (held_values.size() == 0) begin
          res.status = bdq_pkg::STAT_EMPTY;
        end else begin
          // search from the front, take the first match only
          foreach (held_values[i]) begin
            if (hit < 0 && held_values[i] == val) hit = i;
          end
          if (hit < 0) begin
            res.status = bdq_pkg::STAT_NOT_FOUND;
          end else begin
            res.removed_value = held_values[hit];
            held_values.delete(hit);
          end
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (held_values.size() == 0) res.status = bdq_pkg::STAT_EMPTY;
        else res.removed_value = held_values.pop_front();
      end
      bdq_pkg::OP_POP_BACK: begin
        if (held_values.size() == 0) res.status = bdq_pkg::STAT_EMPTY;
        else res.removed_value = held_values.pop_back();
      end
      default: begin
      end
    endcase
    res.entry_count = bdq_pkg::CNT_OUT_W'(held_values.size());
    return res;
  endfunction

  // Predict on every accepted request
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pending_results.push_back(apply_deque_op(in_tdata[2:0], in_tdata[34:3]));
    end
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata 0x%010h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tdata[1:0]);
          mismatch_count++;
        end
        if (out_tdata[33:2] !== want.removed_value) begin
          $error("removed_value: expected %0d, actual %0d",
                 $signed(want.removed_value), $signed(out_tdata[33:2]));
          mismatch_count++;
        end
        if (out_tdata[38:34] !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count,
                 out_tdata[38:34]);
          mismatch_count++;
        end
      end
    end
  end

  // Stall the result side in runs of varying density, or hold off on demand
  initial begin
    int stall_pct;
    int run_left;
    stall_pct  = 0;
    run_left   = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 20;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          run_left = $urandom_range(120, 20);
        end
        run_left--;
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Offer one request, inserting a gap between bursts, and hold until accepted
  task automatic send_request(input logic [bdq_pkg::OP_W-1:0] op,
                              input logic [bdq_pkg::VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      burst_left = $urandom_range(30, 1);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, val, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Draw a value: mostly small or already held so deletes hit, sometimes extreme
  function automatic logic [bdq_pkg::VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 35) return bdq_pkg::VAL_W'($urandom_range(7)) - bdq_pkg::VAL_W'(4);
    if (r < 60 && held_values.size() > 0)
      return held_values[$urandom_range(held_values.size() - 1)];
    if (r < 66) begin
      case ($urandom_range(3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return VAL_ONES;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // Draw an operation with the given share of pushes
  function automatic logic [bdq_pkg::OP_W-1:0] pick_op(input int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 2) return bdq_pkg::OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    if (r < 2 + push_pct)
      return ($urandom_range(1) != 0) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
    case ($urandom_range(4))
      0, 1:    return bdq_pkg::OP_DELETE;
      2:       return bdq_pkg::OP_POP_FRONT;
      default: return bdq_pkg::OP_POP_BACK;
    endcase
  endfunction

  // Removal requests on an empty store
  task automatic test_empty_store();
    send_request(bdq_pkg::OP_POP_FRONT, VAL_ONES);
    send_request(bdq_pkg::OP_POP_BACK, '0);
    send_request(bdq_pkg::OP_DELETE, VAL_MIN);
    wait_for_results();
  endtask

  // Fill to capacity with extreme values, then push past full at both ends
  task automatic test_fill_to_capacity();
    logic [bdq_pkg::VAL_W-1:0] fill_vals [DEPTH] = '{
      VAL_MIN, VAL_MAX, VAL_ONES, 32'h0, VAL_MIN, 32'h1, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h2, 32'hFFFF_FFFE, 32'h0000_FFFF, 32'hFFFF_0000, 32'h3, 32'h8000_0001,
      32'h7FFF_FFFE, 32'h4};
    for (int i = 0; i < DEPTH; i++) begin
      send_request((i % 2 == 0) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT,
                   fill_vals[i]);
    end
    send_request(bdq_pkg::OP_PUSH_FRONT, VAL_MAX);
    send_request(bdq_pkg::OP_PUSH_BACK, VAL_MIN);
  endtask

  // Undefined operation codes leave the store alone
  task automatic test_unused_codes();
    for (int code = OP_UNUSED_LO; code <= OP_UNUSED_HI; code++) begin
      send_request(bdq_pkg::OP_W'(code), VAL_ONES);
    end
  endtask

  // Delete of a missing value, then of a duplicated one
  task automatic test_delete_cases();
    send_request(bdq_pkg::OP_DELETE, VAL_ABSENT);
    send_request(bdq_pkg::OP_DELETE, VAL_MIN);
    wait_for_results();
  endtask

  // Block the result side while requests keep coming, so the input backs up
  task automatic test_receiver_hold();
    hold_off_req = 1'b1;
    burst_left   = 40;
    for (int i = 0; i < 24; i++) send_request(pick_op(50), pick_value());
    wait_for_results();
  endtask

  // Alternate push-heavy and pop-heavy phases so the store swings full and empty
  task automatic test_random_traffic();
    int push_pct;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      push_pct = (p % 2 == 0) ? $urandom_range(85, 65) : $urandom_range(35, 15);
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(pick_op(push_pct), pick_value());
      if (p == RANDOM_PHASES / 2) wait_for_results();
    end
  endtask

  initial begin
    mismatch_count = 0;
    burst_left     = 0;
    hold_off_req   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_fill_to_capacity();
    test_unused_codes();
    test_delete_cases();
    test_receiver_hold();
    test_random_traffic();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
